FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Implication checked in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/pcxd_pkg.sv
// Types and constants of the PCX run-length image decoder
`default_nettype none

package pcxd_pkg;

  localparam int unsigned LINE_PITCH = 320;
  localparam int unsigned MAX_HEIGHT = 200;
  localparam int unsigned HDR_LEN    = 128;

  localparam int unsigned XW   = 9;
  localparam int unsigned YW   = 8;
  localparam int unsigned RUNW = 6;
  localparam int unsigned HCW  = 7;

  localparam logic [7:0] HDR_MANUF    = 8'h0A;
  localparam logic [7:0] HDR_VERSION  = 8'd5;
  localparam logic [7:0] HDR_ENCODING = 8'd1;
  localparam logic [7:0] HDR_BPP      = 8'd8;
  localparam logic [1:0] RUN_TAG      = 2'b11;

  localparam logic [HCW-1:0] OFS_MANUF    = 7'd0;
  localparam logic [HCW-1:0] OFS_VERSION  = 7'd1;
  localparam logic [HCW-1:0] OFS_ENCODING = 7'd2;
  localparam logic [HCW-1:0] OFS_BPP      = 7'd3;
  localparam logic [HCW-1:0] OFS_XMAX_LO  = 7'd8;
  localparam logic [HCW-1:0] OFS_XMAX_HI  = 7'd9;
  localparam logic [HCW-1:0] OFS_YMAX_LO  = 7'd10;
  localparam logic [HCW-1:0] OFS_YMAX_HI  = 7'd11;
  localparam logic [HCW-1:0] OFS_LAST     = 7'(HDR_LEN - 1);

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_BAD_HDR   = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [RUNW-1:0] run_len;
    logic [XW-1:0]   x;
    logic [YW-1:0]   y;
    logic [7:0]      value;
    logic            term;
    kind_e           term_kind;
  } job_t;

endpackage

`default_nettype wire

FILE: rtl/pcxd_core.sv
// Header check and run decode state, one request per cycle while accept_i is high
`default_nettype none

module pcxd_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire logic [7:0]   file_byte_i,
  input  wire logic         first_byte_i,
  input  wire logic         end_of_file_i,
  output pcxd_pkg::job_t    job_o
);
  import pcxd_pkg::*;

  phase_e          phase_q, phase_d;
  logic [HCW-1:0]  hc_q, hc_d;
  logic            bad_q, bad_d;
  logic [XW-1:0]   re_q, re_d;
  logic [YW-1:0]   rc_q, rc_d;
  logic [XW-1:0]   col_q, col_d;
  logic [YW-1:0]   row_q, row_d;
  logic [RUNW-1:0] pend_q, pend_d;
  logic            await_q, await_d;

  phase_e          ph;
  logic [HCW-1:0]  hc;
  logic            bad;
  logic [XW-1:0]   re;
  logic [YW-1:0]   rc;
  logic [XW-1:0]   col;
  logic [YW-1:0]   row;
  logic            have;
  logic [RUNW-1:0] cnt;
  logic [15:0]     wide;
  logic [XW:0]     col_sum;
  logic [YW-1:0]   row_n;

  always_comb begin
    ph   = first_byte_i ? PH_HEADER : phase_q;
    hc   = first_byte_i ? '0 : hc_q;
    bad  = first_byte_i ? 1'b0 : bad_q;
    re   = first_byte_i ? '0 : re_q;
    rc   = first_byte_i ? '0 : rc_q;
    col  = first_byte_i ? '0 : col_q;
    row  = first_byte_i ? '0 : row_q;

    phase_d = ph;
    hc_d    = hc;
    bad_d   = bad;
    re_d    = re;
    rc_d    = rc;
    col_d   = col;
    row_d   = row;
    pend_d  = first_byte_i ? '0 : pend_q;
    await_d = first_byte_i ? 1'b0 : await_q;

    have    = 1'b0;
    cnt     = '0;
    wide    = '0;
    col_sum = '0;
    row_n   = row;

    job_o.run_len   = '0;
    job_o.x         = col;
    job_o.y         = row;
    job_o.value     = file_byte_i;
    job_o.term      = 1'b0;
    job_o.term_kind = KIND_PIXEL;

    unique case (ph)
      PH_HEADER: begin
        unique case (hc)
          OFS_MANUF:    if (file_byte_i != HDR_MANUF) bad_d = 1'b1;
          OFS_VERSION:  if (file_byte_i != HDR_VERSION) bad_d = 1'b1;
          OFS_ENCODING: if (file_byte_i != HDR_ENCODING) bad_d = 1'b1;
          OFS_BPP:      if (file_byte_i != HDR_BPP) bad_d = 1'b1;
          OFS_XMAX_LO:  re_d = {1'b0, file_byte_i};
          OFS_XMAX_HI: begin
            wide = {file_byte_i, re[7:0]};
            re_d = wide[XW-1:0];
            if (wide >= 16'(LINE_PITCH)) bad_d = 1'b1;
          end
          OFS_YMAX_LO:  rc_d = file_byte_i;
          OFS_YMAX_HI: begin
            wide = {file_byte_i, rc};
            rc_d = wide[YW-1:0];
            if (wide >= 16'(MAX_HEIGHT)) bad_d = 1'b1;
          end
          default: ;
        endcase
        hc_d = hc + 1'b1;
        if (hc == OFS_LAST) begin
          if (bad_d) begin
            job_o.term      = 1'b1;
            job_o.term_kind = KIND_BAD_HDR;
            phase_d         = PH_DONE;
          end else if (rc_d == '0) begin
            job_o.term      = 1'b1;
            job_o.term_kind = KIND_DONE;
            phase_d         = PH_DONE;
          end else if (end_of_file_i) begin
            job_o.term      = 1'b1;
            job_o.term_kind = KIND_MALFORMED;
            phase_d         = PH_DONE;
          end else begin
            phase_d = PH_DATA;
            col_d   = '0;
            row_d   = '0;
            await_d = 1'b0;
          end
        end else if (end_of_file_i) begin
          job_o.term      = 1'b1;
          job_o.term_kind = KIND_MALFORMED;
          phase_d         = PH_DONE;
        end
      end
      PH_DATA: begin
        if (await_d) begin
          cnt     = pend_d;
          await_d = 1'b0;
          have    = 1'b1;
        end else if (file_byte_i[7:6] == RUN_TAG) begin
          pend_d  = file_byte_i[RUNW-1:0];
          await_d = 1'b1;
          if (end_of_file_i) begin
            job_o.term      = 1'b1;
            job_o.term_kind = KIND_MALFORMED;
            phase_d         = PH_DONE;
          end
        end else begin
          cnt  = RUNW'(1);
          have = 1'b1;
        end
        if (have) begin
          col_sum = {4'b0, cnt} + {1'b0, col};
          if (col_sum > ({1'b0, re} + (XW+1)'(2))) begin
            job_o.term      = 1'b1;
            job_o.term_kind = KIND_MALFORMED;
            phase_d         = PH_DONE;
          end else begin
            job_o.run_len = cnt;
            if (col_sum > {1'b0, re}) begin
              col_d = '0;
              row_n = row + 1'b1;
            end else begin
              col_d = col_sum[XW-1:0];
            end
            row_d = row_n;
            if (row_n >= rc) begin
              job_o.term      = 1'b1;
              job_o.term_kind = KIND_DONE;
              phase_d         = PH_DONE;
            end else if (end_of_file_i) begin
              job_o.term      = 1'b1;
              job_o.term_kind = KIND_MALFORMED;
              phase_d         = PH_DONE;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hc_q    <= '0;
      bad_q   <= 1'b0;
      re_q    <= '0;
      rc_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
      pend_q  <= '0;
      await_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      bad_q   <= bad_d;
      re_q    <= re_d;
      rc_q    <= rc_d;
      col_q   <= col_d;
      row_q   <= row_d;
      pend_q  <= pend_d;
      await_q <= await_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pcxd_emit.sv
// Run register and result register: one result per cycle while the output is ready
`default_nettype none

module pcxd_emit (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     job_load_i,
  input  wire pcxd_pkg::job_t           job_i,
  output logic                          job_free_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output pcxd_pkg::kind_e               kind_o,
  output logic [pcxd_pkg::XW-1:0]       pixel_x_o,
  output logic [pcxd_pkg::YW-1:0]       pixel_y_o,
  output logic [7:0]                    pixel_value_o,
  output logic                          last_of_run_o
);
  import pcxd_pkg::*;

  job_t        job_q, job_d;
  logic        ov_q, ov_d;
  kind_e       kind_q, kind_d;
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [7:0]  v_q, v_d;
  logic        last_q, last_d;

  logic pix_zero, busy, out_load, last_step;

  always_comb begin
    pix_zero   = (job_q.run_len == '0);
    busy       = !pix_zero || job_q.term;
    out_load   = !ov_q || out_ready_i;
    last_step  = (job_q.run_len == RUNW'(1) && !job_q.term) || (pix_zero && job_q.term);
    job_free_o = !busy || (out_load && last_step);

    job_d  = job_q;
    ov_d   = ov_q;
    kind_d = kind_q;
    x_d    = x_q;
    y_d    = y_q;
    v_d    = v_q;
    last_d = last_q;

    if (out_load) begin
      ov_d = busy;
      if (!pix_zero) begin
        kind_d        = KIND_PIXEL;
        x_d           = job_q.x;
        y_d           = job_q.y;
        v_d           = job_q.value;
        last_d        = last_step;
        job_d.run_len = job_q.run_len - 1'b1;
        job_d.x       = job_q.x + 1'b1;
      end else if (job_q.term) begin
        kind_d     = job_q.term_kind;
        x_d        = '0;
        y_d        = '0;
        v_d        = '0;
        last_d     = 1'b1;
        job_d.term = 1'b0;
      end
    end
    if (job_load_i) begin
      job_d = job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      job_q <= job_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    x_q    <= x_d;
    y_q    <= y_d;
    v_q    <= v_d;
    last_q <= last_d;
  end

  assign out_valid_o   = ov_q;
  assign kind_o        = kind_q;
  assign pixel_x_o     = x_q;
  assign pixel_y_o     = y_q;
  assign pixel_value_o = v_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

FILE: rtl/pcx_rle_image_decoder.sv
// Top level of the PCX run-length image decoder, 8 bits per pixel
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_ready_o   file_byte_i, first_byte_i, end_of_file_i
//  out      output     out_valid_o / out_ready_i kind_o, pixel_x_o, pixel_y_o,
//                                                pixel_value_o, last_of_run_o
//
// A request is decoded in the cycle it is taken; its results leave one per cycle while the output is ready.
// A byte giving several results keeps the next request waiting until its last result is loaded; bytes
// with none or one result are taken every cycle while the output is ready.
// A taken request passes through the run register and then the result register before its first result appears.
// Reset returns the decoder to the header phase; first_byte_i restarts it too.
// A stalled output holds the result register; once the run register holds a request
// that cannot drain, the input waits.
`default_nettype none

module pcx_rle_image_decoder (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [7:0]             file_byte_i,
  input  wire logic                   first_byte_i,
  input  wire logic                   end_of_file_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [pcxd_pkg::XW-1:0]     pixel_x_o,
  output logic [pcxd_pkg::YW-1:0]     pixel_y_o,
  output logic [7:0]                  pixel_value_o,
  output logic                        last_of_run_o
);
  import pcxd_pkg::*;

  logic  accept;
  logic  job_free;
  job_t  job;
  kind_e kind;

  assign in_ready_o = job_free;
  assign accept     = in_valid_i && job_free;

  pcxd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .file_byte_i   (file_byte_i),
    .first_byte_i  (first_byte_i),
    .end_of_file_i (end_of_file_i),
    .job_o         (job)
  );

  pcxd_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_load_i    (accept && ((job.run_len != '0) || job.term)),
    .job_i         (job),
    .job_free_o    (job_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_value_o (pixel_value_o),
    .last_of_run_o (last_of_run_o)
  );

  assign kind_o = kind;

endmodule

`default_nettype wire

FILE: rtl/pcxd_checker.sv
// Port checker for the PCX decoder and its bind
`include "assert_macros.svh"
`default_nettype none

module pcxd_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [1:0]             kind_o,
  input wire logic [pcxd_pkg::XW-1:0] pixel_x_o,
  input wire logic [pcxd_pkg::YW-1:0] pixel_y_o,
  input wire logic [7:0]             pixel_value_o,
  input wire logic                   last_of_run_o
);
  import pcxd_pkg::*;

  logic status_seen;
  logic pixel_seen;
  logic status_zero;
  logic pixel_in_range;

  assign status_seen    = out_valid_o && (kind_o != KIND_PIXEL);
  assign pixel_seen     = out_valid_o && (kind_o == KIND_PIXEL);
  assign status_zero    = (pixel_x_o == '0) && (pixel_y_o == '0) && (pixel_value_o == '0);
  assign pixel_in_range = (pixel_x_o <= XW'(LINE_PITCH)) && (pixel_y_o < YW'(MAX_HEIGHT));

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_CLK(a_status_zero, clk_i, rst_ni, status_seen |-> status_zero)
  `ASSERT_CLK(a_status_last, clk_i, rst_ni, status_seen |-> last_of_run_o)
  `ASSERT_CLK(a_pixel_range, clk_i, rst_ni, pixel_seen |-> pixel_in_range)

endmodule

bind pcx_rle_image_decoder pcxd_checker u_checker (.*);

`default_nettype wire
